// File: rtl/pmt_pkg.sv
// Shared types and fixed constants for the packed matrix transpose block.
package pmt_pkg;

    localparam int WORD_W    = 32;  // packed word width
    localparam int ADDR_W    = 14;  // output word address width
    localparam int CFG_W     = 7;   // size register width
    localparam int CFG_IDX_W = 1;   // register index width

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_TILES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_TILES = 1'd1;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } pmt_state_t;

    // controller -> datapath
    typedef struct packed {
        logic store;    // write input word into the line store
        logic fetch;    // read the tile column, hold the last-row word
        logic k_inc;    // step to next transposed word
        logic advance;  // step the position counters
    } pmt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last_row; // current row is the last of its band
        logic last_k;   // current transposed word is the tile's last
    } pmt_status_t;

endpackage

// File: rtl/packed_matrix_transpose.sv
// Top level of the packed matrix transpose: controller, datapath and checks.
//
// Streams a matrix of ACT_BITS-wide activations packed ACTS_PER_WORD to a
// 32-bit word (first activation in the top bits) in row-major order and
// emits it transposed, tile by tile. Set width_tiles (register 0, words per
// row) and height_tiles (register 1, bands of ACTS_PER_WORD rows) while the
// block is idle; 0 reads as 1, values above the maximum read as the maximum,
// and any write restarts at the first word of a matrix. The upper rows of
// each band are held in a line store of ACTS_PER_WORD-1 RAMs, one per row,
// MAX_WIDTH_TILES words deep. Words of an upper row are taken back to back.
// Taking a word of a band's last row also reads the tile column from all
// row RAMs at once; the block then presents ACTS_PER_WORD output words, one
// a cycle while m_ready is high, and takes no input meanwhile. Each output
// word carries its address (column*ACTS_PER_WORD + k)*height_tiles + band,
// modulo 2^14, a tile-end flag and a matrix-end flag. The line store needs
// no clearing after reset.
module packed_matrix_transpose #(
    parameter int ACTS_PER_WORD    = 4,
    parameter int ACT_BITS         = 8,
    parameter int MAX_WIDTH_TILES  = 64,
    parameter int MAX_HEIGHT_TILES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [pmt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pmt_pkg::CFG_W-1:0]     cfg_wr_data,
    // input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pmt_pkg::WORD_W-1:0]    s_in_word,
    // transposed words
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pmt_pkg::WORD_W-1:0]    m_out_word,
    output logic [pmt_pkg::ADDR_W-1:0]    m_out_address,
    output logic                          m_last_of_tile,
    output logic                          m_matrix_done
);

    pmt_pkg::pmt_cmd_t    cmd;
    pmt_pkg::pmt_status_t status;

    // controller: handshakes and sequencing
    pmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: counters, line store, transpose and addressing
    pmt_datapath #(
        .ACTS_PER_WORD    (ACTS_PER_WORD),
        .ACT_BITS         (ACT_BITS),
        .MAX_WIDTH_TILES  (MAX_WIDTH_TILES),
        .MAX_HEIGHT_TILES (MAX_HEIGHT_TILES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_word      (s_in_word),
        .cmd          (cmd),
        .status       (status),
        .out_word     (m_out_word),
        .out_address  (m_out_address),
        .last_of_tile (m_last_of_tile),
        .matrix_done  (m_matrix_done)
    );

    // never take a word while a transposed word is on offer
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while output pending");

    // matrix end only ever coincides with a tile end
    a_done_on_tile_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_matrix_done) |-> m_last_of_tile)
        else $error("matrix_done without last_of_tile");

    // the tile's last word hands back to the input side
    a_tile_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_of_tile) |=> (!m_valid && s_ready))
        else $error("output continued past tile end");

    // a fresh tile always opens at its first word
    a_tile_starts_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !m_last_of_tile)
        else $error("tile did not start at its first word");

endmodule

// File: rtl/pmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/pmt_ctrl.sv
// Controller FSM: takes words in, sequences the transposed output words.
module pmt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  pmt_pkg::pmt_status_t status,
    output pmt_pkg::pmt_cmd_t    cmd
);

    pmt_pkg::pmt_state_t state_reg;
    pmt_pkg::pmt_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pmt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pmt_pkg::ST_IDLE: begin
                if (s_valid && status.last_row) begin
                    state_next = pmt_pkg::ST_EMIT;
                end
            end
            pmt_pkg::ST_EMIT: begin
                if (m_ready && status.last_k) begin
                    state_next = pmt_pkg::ST_IDLE;
                end
            end
            default: state_next = pmt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd         = '0;
        case (state_reg)
            pmt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.store   = !status.last_row;
                    cmd.fetch   = status.last_row;
                    cmd.advance = !status.last_row;
                end
            end
            pmt_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.k_inc   = 1'b1;
                    cmd.advance = status.last_k;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/pmt_datapath.sv
// Datapath: size registers, position counters, line store and transpose mux.
module pmt_datapath #(
    parameter int ACTS_PER_WORD    = 4,
    parameter int ACT_BITS         = 8,
    parameter int MAX_WIDTH_TILES  = 64,
    parameter int MAX_HEIGHT_TILES = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pmt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pmt_pkg::CFG_W-1:0]       cfg_wr_data,
    input  logic [pmt_pkg::WORD_W-1:0]      in_word,
    input  pmt_pkg::pmt_cmd_t               cmd,
    output pmt_pkg::pmt_status_t            status,
    output logic [pmt_pkg::WORD_W-1:0]      out_word,
    output logic [pmt_pkg::ADDR_W-1:0]      out_address,
    output logic                            last_of_tile,
    output logic                            matrix_done
);

    localparam int COL_W  = MAX_WIDTH_TILES > 1 ? $clog2(MAX_WIDTH_TILES) : 1;
    localparam int BAND_W = MAX_HEIGHT_TILES > 1 ? $clog2(MAX_HEIGHT_TILES) : 1;
    localparam int SUB_W  = $clog2(ACTS_PER_WORD);
    localparam int TOT_W  = ACTS_PER_WORD * ACT_BITS;
    localparam int N_ROWS = ACTS_PER_WORD - 1;

    localparam logic [SUB_W-1:0]  SUB_LAST  = SUB_W'(ACTS_PER_WORD - 1);
    localparam logic [COL_W-1:0]  COL_MAX   = COL_W'(MAX_WIDTH_TILES - 1);
    localparam logic [BAND_W-1:0] BAND_MAX  = BAND_W'(MAX_HEIGHT_TILES - 1);

    logic [COL_W-1:0]          col_reg, col_next;
    logic [SUB_W-1:0]          sub_reg, sub_next;
    logic [BAND_W-1:0]         band_reg, band_next;
    logic [SUB_W-1:0]          k_reg;
    logic [COL_W-1:0]          col_last_reg;
    logic [BAND_W-1:0]         band_last_reg;
    logic [pmt_pkg::WORD_W-1:0] word_reg;

    logic [pmt_pkg::WORD_W-1:0] row_rd [N_ROWS];
    logic                       col_end, band_end, last_k;
    logic [TOT_W-1:0]           res_wide;
    logic [pmt_pkg::ADDR_W-1:0] tile_col, h_eff;

    assign col_end  = (col_reg == col_last_reg);
    assign band_end = (band_reg == band_last_reg);
    assign last_k   = (k_reg == SUB_LAST);

    assign status.last_row = (sub_reg == SUB_LAST);
    assign status.last_k   = last_k;

    // one store per upper row of the band, indexed by column
    for (genvar g = 0; g < N_ROWS; g++) begin : g_row
        pmt_ram #(
            .WIDTH (pmt_pkg::WORD_W),
            .DEPTH (MAX_WIDTH_TILES)
        ) u_row_ram (
            .aclk    (aclk),
            .wr_en   (cmd.store && (sub_reg == SUB_W'(g))),
            .wr_addr (col_reg),
            .wr_data (in_word),
            .rd_en   (cmd.fetch),
            .rd_addr (col_reg),
            .rd_data (row_rd[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            word_reg <= in_word;
        end
    end

    // position step: column, then row within band, then band
    always_comb begin
        col_next  = col_reg + COL_W'(1);
        sub_next  = sub_reg;
        band_next = band_reg;
        if (col_end) begin
            col_next = '0;
            if (status.last_row) begin
                sub_next  = '0;
                band_next = band_end ? '0 : band_reg + BAND_W'(1);
            end else begin
                sub_next = sub_reg + SUB_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            sub_reg       <= '0;
            band_reg      <= '0;
            k_reg         <= '0;
            col_last_reg  <= '0;
            band_last_reg <= '0;
        end else if (cfg_wr_en) begin
            // any valid write restarts the matrix; store contents kept
            if (cfg_index == pmt_pkg::REG_WIDTH_TILES ||
                cfg_index == pmt_pkg::REG_HEIGHT_TILES) begin
                col_reg  <= '0;
                sub_reg  <= '0;
                band_reg <= '0;
                k_reg    <= '0;
            end
            if (cfg_index == pmt_pkg::REG_WIDTH_TILES) begin
                if (cfg_wr_data == '0) begin
                    col_last_reg <= '0;
                end else if (int'(cfg_wr_data) > MAX_WIDTH_TILES) begin
                    col_last_reg <= COL_MAX;
                end else begin
                    col_last_reg <= COL_W'(cfg_wr_data - pmt_pkg::CFG_W'(1));
                end
            end
            if (cfg_index == pmt_pkg::REG_HEIGHT_TILES) begin
                if (cfg_wr_data == '0) begin
                    band_last_reg <= '0;
                end else if (int'(cfg_wr_data) > MAX_HEIGHT_TILES) begin
                    band_last_reg <= BAND_MAX;
                end else begin
                    band_last_reg <= BAND_W'(cfg_wr_data - pmt_pkg::CFG_W'(1));
                end
            end
        end else begin
            if (cmd.advance) begin
                col_reg  <= col_next;
                sub_reg  <= sub_next;
                band_reg <= band_next;
            end
            if (cmd.k_inc) begin
                k_reg <= last_k ? '0 : k_reg + SUB_W'(1);
            end
        end
    end

    // slot s of the result holds activation k of tile row s
    always_comb begin
        logic [TOT_W-1:0] src_wide;
        int               sh;
        sh       = (ACTS_PER_WORD - 1 - int'(k_reg)) * ACT_BITS;
        res_wide = '0;
        for (int s = 0; s < N_ROWS; s++) begin
            src_wide = TOT_W'(row_rd[s]);
            res_wide[(ACTS_PER_WORD - 1 - s) * ACT_BITS +: ACT_BITS] =
                src_wide[sh +: ACT_BITS];
        end
        src_wide = TOT_W'(word_reg);
        res_wide[ACT_BITS-1:0] = src_wide[sh +: ACT_BITS];
    end

    assign out_word = pmt_pkg::WORD_W'(res_wide);

    // address arithmetic kept modulo 2^ADDR_W throughout
    assign tile_col    = pmt_pkg::ADDR_W'(col_reg) * pmt_pkg::ADDR_W'(ACTS_PER_WORD)
                         + pmt_pkg::ADDR_W'(k_reg);
    assign h_eff       = pmt_pkg::ADDR_W'(band_last_reg) + pmt_pkg::ADDR_W'(1);
    assign out_address = tile_col * h_eff + pmt_pkg::ADDR_W'(band_reg);

    assign last_of_tile = last_k;
    assign matrix_done  = last_k && col_end && band_end;

endmodule

// File: sim/packed_matrix_transpose_tb.sv
// Self-checking testbench for packed_matrix_transpose: streamed words against a tile predictor.
`timescale 1ns / 1ps

module packed_matrix_transpose_tb;

    localparam int ACTS_PER_WORD    = 4;
    localparam int ACT_BITS         = 8;
    localparam int MAX_WIDTH_TILES  = 64;
    localparam int MAX_HEIGHT_TILES = 64;
    localparam int SETTLE_CYCLES    = 12;   // margin for a full tile pass

    // one transposed word as it should leave the block
    typedef struct packed {
        logic [pmt_pkg::WORD_W-1:0] data;
        logic [pmt_pkg::ADDR_W-1:0] addr;
        logic                       tile_end;
        logic                       matrix_end;
    } tile_word_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [pmt_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pmt_pkg::CFG_W-1:0]     cfg_wr_data;
    logic                          s_valid;
    logic                          s_ready;
    logic [pmt_pkg::WORD_W-1:0]    s_in_word;
    logic                          m_valid;
    logic                          m_ready;
    logic [pmt_pkg::WORD_W-1:0]    m_out_word;
    logic [pmt_pkg::ADDR_W-1:0]    m_out_address;
    logic                          m_last_of_tile;
    logic                          m_matrix_done;

    packed_matrix_transpose #(
        .ACTS_PER_WORD   (ACTS_PER_WORD),
        .ACT_BITS        (ACT_BITS),
        .MAX_WIDTH_TILES (MAX_WIDTH_TILES),
        .MAX_HEIGHT_TILES(MAX_HEIGHT_TILES)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_word     (s_in_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_word    (m_out_word),
        .m_out_address (m_out_address),
        .m_last_of_tile(m_last_of_tile),
        .m_matrix_done (m_matrix_done)
    );

    // input words not yet offered, and transposed words not yet seen
    logic [pmt_pkg::WORD_W-1:0] pending_words[$];
    tile_word_t                 tile_words[$];
    tile_word_t                 want;

    // predictor copy of the size registers, position and line store
    logic [pmt_pkg::CFG_W-1:0]  width_tiles_q;
    logic [pmt_pkg::CFG_W-1:0]  height_tiles_q;
    int unsigned                row_pos;
    int unsigned                col_pos;
    logic [pmt_pkg::WORD_W-1:0] band_rows[ACTS_PER_WORD-1][MAX_WIDTH_TILES];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Predictor: upper rows of a band go to the line store; a word of the
    // band's last row closes a tile and yields ACTS_PER_WORD transposed words.
    task automatic transpose_word(input logic [pmt_pkg::WORD_W-1:0] word_in);
        int unsigned                eff_w;
        int unsigned                eff_h;
        int unsigned                rows;
        int unsigned                band;
        int unsigned                sub;
        int unsigned                sh;
        logic [63:0]                packed_out;
        logic [pmt_pkg::WORD_W-1:0] src;
        logic [ACT_BITS-1:0]        act;
        tile_word_t                 r;
        // zero reads as one, oversize clamps to the maximum
        eff_w = (width_tiles_q == 0) ? 1 :
                (width_tiles_q > MAX_WIDTH_TILES) ? MAX_WIDTH_TILES : width_tiles_q;
        eff_h = (height_tiles_q == 0) ? 1 :
                (height_tiles_q > MAX_HEIGHT_TILES) ? MAX_HEIGHT_TILES : height_tiles_q;
        rows  = eff_h * ACTS_PER_WORD;
        if (col_pos >= eff_w) col_pos = 0;
        if (row_pos >= rows) row_pos = 0;
        band = row_pos / ACTS_PER_WORD;
        sub  = row_pos % ACTS_PER_WORD;
        if (sub < ACTS_PER_WORD - 1) begin
            band_rows[sub][col_pos] = word_in;
        end else begin
            for (int k = 0; k < ACTS_PER_WORD; k++) begin
                packed_out = '0;
                // slot s of output word k takes activation k of tile row s
                for (int s = 0; s < ACTS_PER_WORD; s++) begin
                    src = (s == ACTS_PER_WORD - 1) ? word_in : band_rows[s][col_pos];
                    sh  = (ACTS_PER_WORD - 1 - k) * ACT_BITS;
                    act = (sh < pmt_pkg::WORD_W) ? ACT_BITS'(src >> sh) : '0;
                    sh  = (ACTS_PER_WORD - 1 - s) * ACT_BITS;
                    if (sh < pmt_pkg::WORD_W) packed_out |= 64'(act) << sh;
                end
                r.data       = packed_out[pmt_pkg::WORD_W-1:0];
                r.addr       = pmt_pkg::ADDR_W'((col_pos * ACTS_PER_WORD + k) * eff_h + band);
                r.tile_end   = (k == ACTS_PER_WORD - 1);
                r.matrix_end = r.tile_end && (row_pos + 1 >= rows) && (col_pos + 1 >= eff_w);
                tile_words.push_back(r);
            end
        end
        if (col_pos + 1 >= eff_w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    task automatic check_field(input string what, input logic [pmt_pkg::WORD_W-1:0] want_v,
                               input logic [pmt_pkg::WORD_W-1:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, what, want_v, got_v);
        end
    endtask

    // sampled at the falling edge so every update of the rising edge has landed
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_valid || tile_words.size() != 0);
    endtask

    // Both registers written back to back once the block has gone quiet;
    // each write also restarts the matrix, the line store is kept.
    task automatic set_sizes(input int w_raw, input int h_raw);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= pmt_pkg::REG_WIDTH_TILES;
        cfg_wr_data <= pmt_pkg::CFG_W'(w_raw);
        @(posedge aclk);
        cfg_index   <= pmt_pkg::REG_HEIGHT_TILES;
        cfg_wr_data <= pmt_pkg::CFG_W'(h_raw);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        width_tiles_q  = pmt_pkg::CFG_W'(w_raw);
        height_tiles_q = pmt_pkg::CFG_W'(h_raw);
        row_pos        = 0;
        col_pos        = 0;
    endtask

    // random words, weighted towards the all-ones, all-zeros and lone-activation corners
    task automatic load_words(input int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: begin
                    pending_words.push_back('1);
                end
                1: begin
                    pending_words.push_back('0);
                end
                2: begin
                    pending_words.push_back(pmt_pkg::WORD_W'($urandom_range(1, 255))
                                            << (ACT_BITS * $urandom_range(0, ACTS_PER_WORD - 1)));
                end
                default: begin
                    pending_words.push_back($urandom);
                end
            endcase
        end
    endtask

    // Driver: a new word goes up only once the previous one has been taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_in_word <= '0;
        end else if (!s_valid || s_ready) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid   <= 1'b1;
                s_in_word <= pending_words.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: predict on each accepted input word before checking the output
    // side, so a same-edge result could never race its own expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (s_valid && s_ready) transpose_word(s_in_word);
            if (m_valid && m_ready) begin
                if (tile_words.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word, expected none, actual %0h @ %0h",
                             $time, m_out_word, m_out_address);
                end else begin
                    want = tile_words.pop_front();
                    check_field("out_word", want.data, m_out_word);
                    check_field("out_address", pmt_pkg::WORD_W'(want.addr),
                                pmt_pkg::WORD_W'(m_out_address));
                    check_field("last_of_tile", pmt_pkg::WORD_W'(want.tile_end),
                                pmt_pkg::WORD_W'(m_last_of_tile));
                    check_field("matrix_done", pmt_pkg::WORD_W'(want.matrix_end),
                                pmt_pkg::WORD_W'(m_matrix_done));
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        int random_items;
        int phase;
        int w_raw;
        int h_raw;
        int n;
        int half;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = pmt_pkg::REG_WIDTH_TILES;
        cfg_wr_data    = '0;
        width_tiles_q  = pmt_pkg::CFG_W'(1);
        height_tiles_q = pmt_pkg::CFG_W'(1);
        row_pos        = 0;
        col_pos        = 0;
        send_idle_pct  = 17;
        recv_idle_pct  = 62;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset sizes give a single 1x1 tile: corner words in every row
        pending_words.push_back(32'hFFFF_FFFF);
        pending_words.push_back(32'h0000_0000);
        pending_words.push_back(32'h8000_0001);
        pending_words.push_back(32'h7F00_FF01);

        // zero in both registers behaves as one; distinct bytes show the transpose
        set_sizes(0, 0);
        pending_words.push_back(32'h0123_4567);
        pending_words.push_back(32'h89AB_CDEF);
        pending_words.push_back(32'hFEDC_BA98);
        pending_words.push_back(32'h7654_3210);

        // part of a 2x2 matrix, then a write part-way through restarts it
        set_sizes(2, 2);
        load_words(5);
        set_sizes(3, 1);
        load_words(12);

        // random sizes, mostly small, with partial and repeated matrices
        random_items = 0;
        phase        = 0;
        while (random_items < 120) begin
            if (random_items < 40) begin
                send_idle_pct = 17;
                recv_idle_pct = 62;
            end else if (random_items < 80) begin
                send_idle_pct = 62;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            w_raw = $urandom_range(0, 5);
            h_raw = $urandom_range(0, 5);
            set_sizes(w_raw, h_raw);
            n = $urandom_range(2, 2 * ACTS_PER_WORD * (w_raw == 0 ? 1 : w_raw)
                                    * (h_raw == 0 ? 1 : h_raw));
            if (n > 24) n = 24;
            if (phase == 2) begin
                // sender holds off mid-matrix until every tile word is out
                half = n / 2;
                load_words(half);
                wait_idle();
                load_words(n - half);
            end else begin
                load_words(n);
            end
            random_items += n;
            phase++;
        end

        // oversized height clamps to the maximum: first few bands only
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_sizes(1, 127);
        load_words(8 * ACTS_PER_WORD);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS packed_matrix_transpose");
        end else begin
            $display("FAIL packed_matrix_transpose");
        end
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("FAIL packed_matrix_transpose");
        $finish;
    end

endmodule

// File: files.f
rtl/pmt_pkg.sv
rtl/pmt_ram.sv
rtl/pmt_ctrl.sv
rtl/pmt_datapath.sv
rtl/packed_matrix_transpose.sv
sim/packed_matrix_transpose_tb.sv
